@@ sv/arfnr_pkg.sv @@
// package for the audio ring fifo with nearest-neighbour resampling
// holds item structs, register indexes, widths and reset values; no dependencies
package arfnr_pkg;

  localparam int unsigned RING_DEPTH_DEF     = 8192;
  localparam int unsigned REQUEST_FRAMES_DEF = 512;

  localparam int unsigned RATE_W   = 18;
  localparam int unsigned FRAMES_W = 14;
  localparam int unsigned PHASE_W  = 19;
  localparam int unsigned CFG_W    = 18;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAME_W  = 2 * SAMPLE_W;

  localparam logic [RATE_W-1:0]   RATE_IN_RST     = 18'd48000;
  localparam logic [RATE_W-1:0]   RATE_OUT_RST    = 18'd48000;
  localparam logic [FRAMES_W-1:0] RING_FRAMES_RST = 14'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_IN     = 2'd0,
    CFG_RATE_OUT    = 2'd1,
    CFG_RING_FRAMES = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_t;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       request_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       frame_taken;
    logic                       ring_full;
    logic                       from_ring;
  } out_item_t;

  // control carried alongside the memory read
  typedef struct packed {
    logic rd;
    logic real_frame;
    logic left_ok;
    logic right_ok;
    logic taken;
    logic full;
  } s1_ctl_t;

endpackage

@@ sv/audio_ring_fifo_nearest_resample.sv @@
// top level: stereo frame ring with nearest-neighbour write-side resampling
// and mirrored fill on playback underrun; depends on arfnr_pkg
//
//  channel | ports                          | role
//  in      | in_valid in_ready in_item      | write or read item
//  out     | out_valid out_ready out_item   | one result per item
//  cfg     | cfg_we cfg_index cfg_data      | register writes, no wait
//
// one item per cycle while out_ready stays high; an accepted item passes through the memory
// stage (the read of the ring and history memories) and then the output register
// reset is synchronous and clears indices, phase and request counters; no clearing pass
// a stalled output holds the item in the memory stage, and in_ready drops only
// when both stages are full and out_ready is low
module audio_ring_fifo_nearest_resample #(
  parameter int unsigned RING_DEPTH     = arfnr_pkg::RING_DEPTH_DEF,
  parameter int unsigned REQUEST_FRAMES = arfnr_pkg::REQUEST_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  arfnr_pkg::in_item_t              in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output arfnr_pkg::out_item_t             out_item,
  input  logic                             cfg_we,
  input  logic [arfnr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arfnr_pkg::CFG_W-1:0]      cfg_data
);

  localparam int unsigned IW = $clog2(RING_DEPTH);
  localparam int unsigned SW = $clog2(RING_DEPTH + 1);
  localparam int unsigned HW = $clog2(REQUEST_FRAMES);
  localparam int unsigned CW = $clog2(REQUEST_FRAMES + 1);
  localparam int unsigned RST_SIZE =
    (int'(arfnr_pkg::RING_FRAMES_RST) > RING_DEPTH) ? RING_DEPTH :
    int'(arfnr_pkg::RING_FRAMES_RST);
  localparam logic [IW-1:0] STOP_RST = (RST_SIZE == 0) ? '0 : IW'(RST_SIZE - 1);

  localparam int unsigned RW = arfnr_pkg::RATE_W;
  localparam int unsigned PW = arfnr_pkg::PHASE_W;
  localparam int unsigned FW = arfnr_pkg::FRAME_W;
  localparam int unsigned SMW = arfnr_pkg::SAMPLE_W;

  // configuration
  logic [RW-1:0]                  rate_in_r, rate_out_r;
  logic [arfnr_pkg::FRAMES_W-1:0] ring_frames_r;

  // state
  logic [IW-1:0] wr_idx_r, wr_idx_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [IW-1:0] stop_idx_r, stop_idx_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic [CW-1:0] real_cnt_r, real_cnt_nxt;
  logic [CW-1:0] fill_cnt_r, fill_cnt_nxt;
  logic          filling_r, filling_nxt;

  // memories
  logic [FW-1:0] ring_mem [RING_DEPTH];
  logic [FW-1:0] hist_mem [REQUEST_FRAMES];
  logic [FW-1:0] ring_q_r, hist_l_q_r, hist_r_q_r;

  // history write in the cycle after the ring read, forwarded to a fill read
  logic          hw_v_r;
  logic [HW-1:0] hw_addr_r;
  logic [FW-1:0] hw_data_r;
  logic          fwd_l_r, fwd_r_r;
  logic [FW-1:0] hist_l, hist_r;

  // pipeline
  logic                 s1_v_r;
  arfnr_pkg::s1_ctl_t   s1_ctl_r, s1_ctl_nxt;
  logic                 out_v_r;
  arfnr_pkg::out_item_t out_item_r, out_item_nxt;
  logic                 s1_adv, acc;

  // combinational
  logic [SW-1:0] size_w, size_cfg;
  logic          enabled;
  logic [FW-1:0] frame_w;
  logic          ring_we;
  logic          hist_we, hist_re;
  logic [HW-1:0] hist_waddr, hist_laddr, hist_raddr;
  logic          restart;
  logic [CW-1:0] m0, k0;
  logic          fill0;
  logic [CW:0]   cnt_sum;
  logic [PW:0]   phase_sum;
  logic [PW-1:0] phase1;

  function automatic logic [SW-1:0] clip_size(input logic [arfnr_pkg::FRAMES_W-1:0] f);
    logic [31:0] fe;
    fe = 32'(f);
    return (fe > 32'(RING_DEPTH)) ? SW'(RING_DEPTH) : SW'(f);
  endfunction

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
                                             input logic [SW-1:0] sz);
    logic [IW:0] n;
    n = {1'b0, idx} + (IW+1)'(1);
    return ((SW > IW + 1 ? SW : IW + 1)'(n) >= (SW > IW + 1 ? SW : IW + 1)'(sz)) ?
           '0 : n[IW-1:0];
  endfunction

  assign size_w   = clip_size(ring_frames_r);
  assign size_cfg = clip_size(arfnr_pkg::FRAMES_W'(cfg_data));
  assign enabled  = (size_w != '0);
  assign frame_w  = {in_item.right_in, in_item.left_in};

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign acc      = in_valid && in_ready;

  assign cnt_sum  = {1'b0, real_cnt_r} + {1'b0, fill_cnt_r};
  assign restart  = in_item.request_start || (32'(cnt_sum) >= 32'(REQUEST_FRAMES));
  assign m0       = restart ? '0 : real_cnt_r;
  assign k0       = restart ? '0 : fill_cnt_r;
  assign fill0    = restart ? 1'b0 : filling_r;

  assign phase_sum = {1'b0, phase_r} + (PW+1)'(rate_in_r);

  always_comb begin
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    stop_idx_nxt = stop_idx_r;
    phase_nxt    = phase_r;
    real_cnt_nxt = real_cnt_r;
    fill_cnt_nxt = fill_cnt_r;
    filling_nxt  = filling_r;
    s1_ctl_nxt   = '0;
    ring_we      = 1'b0;
    hist_we      = 1'b0;
    hist_re      = 1'b0;
    hist_waddr   = m0[HW-1:0];
    hist_laddr   = HW'(m0 - k0 - CW'(1));
    hist_raddr   = HW'(m0 - k0 - CW'(2));
    phase1       = phase_r;
    if (acc && enabled) begin
      if (in_item.func == arfnr_pkg::FUNC_WRITE) begin
        if (wr_idx_r == stop_idx_r) begin
          s1_ctl_nxt.full = 1'b1;
        end else if (rate_in_r == rate_out_r) begin
          ring_we          = 1'b1;
          wr_idx_nxt       = next_idx(wr_idx_r, size_w);
          s1_ctl_nxt.taken = 1'b1;
        end else begin
          if (phase_r < PW'(rate_out_r)) begin
            ring_we    = 1'b1;
            wr_idx_nxt = next_idx(wr_idx_r, size_w);
            phase1     = phase_sum[PW-1:0];
          end
          if (phase1 >= PW'(rate_out_r)) begin
            s1_ctl_nxt.taken = 1'b1;
            phase_nxt        = phase1 - PW'(rate_out_r);
          end else begin
            phase_nxt = phase1;
          end
        end
      end else begin
        s1_ctl_nxt.rd = 1'b1;
        real_cnt_nxt  = m0;
        fill_cnt_nxt  = k0;
        filling_nxt   = fill0;
        if (!fill0 && (rd_idx_r != wr_idx_r)) begin
          s1_ctl_nxt.real_frame = 1'b1;
          hist_we      = 1'b1;
          real_cnt_nxt = m0 + CW'(1);
          stop_idx_nxt = rd_idx_r;
          rd_idx_nxt   = next_idx(rd_idx_r, size_w);
        end else begin
          hist_re             = 1'b1;
          filling_nxt         = 1'b1;
          s1_ctl_nxt.left_ok  = ({1'b0, m0} >= ({1'b0, k0} + (CW+1)'(1)));
          s1_ctl_nxt.right_ok = ({1'b0, m0} >= ({1'b0, k0} + (CW+1)'(2)));
          fill_cnt_nxt        = k0 + CW'(1);
        end
      end
    end
    // new size empties the ring
    if (cfg_we && (cfg_index == arfnr_pkg::CFG_RING_FRAMES)) begin
      wr_idx_nxt   = '0;
      rd_idx_nxt   = '0;
      stop_idx_nxt = (size_cfg == '0) ? '0 : IW'(size_cfg - SW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wr_idx_r] <= frame_w;
    end
    if (acc && in_item.func == arfnr_pkg::FUNC_READ) begin
      ring_q_r <= ring_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hw_addr_r <= hist_waddr;
    end
    if (hw_v_r) begin
      hist_mem[hw_addr_r] <= ring_q_r;
      hw_data_r           <= ring_q_r;
    end
    if (hist_re) begin
      hist_l_q_r <= hist_mem[hist_laddr];
      hist_r_q_r <= hist_mem[hist_raddr];
      fwd_l_r    <= hw_v_r && (hist_laddr == hw_addr_r);
      fwd_r_r    <= hw_v_r && (hist_raddr == hw_addr_r);
    end
  end

  assign hist_l = fwd_l_r ? hw_data_r : hist_l_q_r;
  assign hist_r = fwd_r_r ? hw_data_r : hist_r_q_r;

  always_comb begin
    out_item_nxt = '0;
    if (s1_ctl_r.rd) begin
      if (s1_ctl_r.real_frame) begin
        out_item_nxt.left_out  = ring_q_r[SMW-1:0];
        out_item_nxt.right_out = ring_q_r[FW-1:SMW];
        out_item_nxt.from_ring = 1'b1;
      end else begin
        out_item_nxt.left_out  = s1_ctl_r.left_ok  ? hist_l[SMW-1:0] : '0;
        out_item_nxt.right_out = s1_ctl_r.right_ok ? hist_r[FW-1:SMW] : '0;
      end
    end
    out_item_nxt.frame_taken = s1_ctl_r.taken;
    out_item_nxt.ring_full   = s1_ctl_r.full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_in_r     <= arfnr_pkg::RATE_IN_RST;
      rate_out_r    <= arfnr_pkg::RATE_OUT_RST;
      ring_frames_r <= arfnr_pkg::RING_FRAMES_RST;
      wr_idx_r      <= '0;
      rd_idx_r      <= '0;
      stop_idx_r    <= STOP_RST;
      phase_r       <= '0;
      real_cnt_r    <= '0;
      fill_cnt_r    <= '0;
      filling_r     <= 1'b0;
      hw_v_r        <= 1'b0;
      s1_v_r        <= 1'b0;
      s1_ctl_r      <= '0;
      out_v_r       <= 1'b0;
    end else begin
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      stop_idx_r <= stop_idx_nxt;
      phase_r    <= phase_nxt;
      real_cnt_r <= real_cnt_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      filling_r  <= filling_nxt;
      hw_v_r     <= hist_we;
      if (cfg_we) begin
        unique case (cfg_index)
          arfnr_pkg::CFG_RATE_IN: begin
            rate_in_r <= cfg_data[RW-1:0];
          end
          arfnr_pkg::CFG_RATE_OUT: begin
            rate_out_r <= cfg_data[RW-1:0];
          end
          arfnr_pkg::CFG_RING_FRAMES: begin
            ring_frames_r <= cfg_data[arfnr_pkg::FRAMES_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_ready) begin
        s1_v_r <= acc;
        if (acc) begin
          s1_ctl_r <= s1_ctl_nxt;
        end
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule
